// ===== hdl/wrms_pkg.sv =====
// package: constants, types and state codes for the windowed rms with min and max block
`default_nettype none

package wrms_pkg;

    localparam int WINDOW_LEN   = 10;
    localparam int SAMPLE_BITS  = 16;
    localparam int SQ_BITS      = 2 * SAMPLE_BITS;
    localparam int SUM_BITS     = 36;
    localparam int FILL_BITS    = $clog2(WINDOW_LEN + 1);
    localparam int PERIOD_BITS  = 16;
    localparam int OUT_BITS     = 16;
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int SQRT_STEPS   = SQ_BITS / 2;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(500);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [FILL_BITS-1:0] fill;
        logic                 out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/wrms_ctrl.sv =====
// controller: state machine sequencing window update, divide, square root and output load
`default_nettype none

module wrms_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wrms_pkg::t_dp_status i_status,
    output wrms_pkg::t_dp_cmd    o_cmd,
    output wrms_pkg::t_state     o_state,
    output logic                 o_busy
);
    import wrms_pkg::*;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_BITS'(DIV_STEPS - 1)) begin
                    n_state = ST_SQRT_LOAD;
                end
            end
            ST_SQRT_LOAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_step          = '0;
                n_state         = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_BITS'(SQRT_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_state = r_state;
    assign o_busy  = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/wrms_dp.sv =====
// datapath: square window, running sum, min and max, period counter, divider, root and output
`default_nettype none

module wrms_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wrms_pkg::t_dp_cmd                  i_cmd,
    output wrms_pkg::t_dp_status               o_status,
    input  wire  [wrms_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  wire                                i_cfg_valid,
    input  wire  [wrms_pkg::PERIOD_BITS-1:0]   i_cfg_data,
    input  wire                                i_stall,
    output logic                               o_valid,
    output logic [wrms_pkg::OUT_BITS-1:0]      o_rms_value,
    output logic [wrms_pkg::OUT_BITS-1:0]      o_min_value,
    output logic [wrms_pkg::OUT_BITS-1:0]      o_max_value
);
    import wrms_pkg::*;

    logic [PERIOD_BITS-1:0] r_period;
    logic [SQ_BITS-1:0]     r_win [0:WINDOW_LEN-1];
    logic [SUM_BITS-1:0]    r_sum;
    logic [FILL_BITS-1:0]   r_fill;
    logic [PERIOD_BITS-1:0] r_pcnt;
    logic [SAMPLE_BITS-1:0] r_min, r_max;

    logic [SUM_BITS-1:0]    r_dvd;
    logic [FILL_BITS-1:0]   r_drem;
    logic [SQ_BITS-1:0]     r_rad;
    logic [SQRT_STEPS+2:0]  r_srem;
    logic [SQRT_STEPS-1:0]  r_root;

    logic                   r_out_valid;
    logic [OUT_BITS-1:0]    r_out_rms, r_out_min, r_out_max;

    logic [SQ_BITS-1:0]     w_sq;
    logic [SUM_BITS-1:0]    n_sum;
    logic [PERIOD_BITS:0]   w_pnext, w_plimit;
    logic [FILL_BITS:0]     w_dtrial;
    logic                   w_dge;
    logic [SQRT_STEPS+2:0]  w_sshift, w_ssub;
    logic                   w_sge;

    assign w_sq     = SQ_BITS'(i_sample) * SQ_BITS'(i_sample);
    assign n_sum    = r_sum - SUM_BITS'(r_win[0]) + SUM_BITS'(w_sq);
    assign w_pnext  = {1'b0, r_pcnt} + 1'b1;
    assign w_plimit = {(r_period == '0), r_period};

    // restoring divide by the fill count, one quotient bit a step
    assign w_dtrial = {r_drem, r_dvd[SUM_BITS-1]};
    assign w_dge    = (w_dtrial >= {1'b0, r_fill});

    // digit-by-digit square root, one root bit a step
    assign w_sshift = {r_srem[SQRT_STEPS:0], r_rad[SQ_BITS-1 -: 2]};
    assign w_ssub   = {1'b0, r_root, 2'b01};
    assign w_sge    = (w_sshift >= w_ssub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_sum  <= '0;
            r_fill <= '0;
            r_pcnt <= '0;
            r_min  <= '0;
            r_max  <= '0;
        end else if (i_cmd.accept) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW_LEN-1] <= w_sq;
            r_sum <= n_sum;
            if (r_fill != FILL_BITS'(WINDOW_LEN)) begin
                r_fill <= r_fill + 1'b1;
            end
            r_pcnt <= (w_pnext >= w_plimit) ? '0 : w_pnext[PERIOD_BITS-1:0];
            if (r_pcnt == '0) begin
                r_min <= i_sample;
                r_max <= i_sample;
            end else begin
                if (i_sample < r_min) begin
                    r_min <= i_sample;
                end
                if (i_sample > r_max) begin
                    r_max <= i_sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd  <= r_sum;
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[SUM_BITS-2:0], w_dge};
            r_drem <= w_dge ? FILL_BITS'(w_dtrial - {1'b0, r_fill}) : w_dtrial[FILL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_rad  <= r_dvd[SQ_BITS-1:0];
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[SQ_BITS-3:0], 2'b00};
            r_srem <= w_sge ? (w_sshift - w_ssub) : w_sshift;
            r_root <= {r_root[SQRT_STEPS-2:0], w_sge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rms <= OUT_BITS'(r_root);
            r_out_min <= OUT_BITS'(r_min);
            r_out_max <= OUT_BITS'(r_max);
        end
    end

    assign o_status.fill     = r_fill;
    assign o_status.out_busy = r_out_valid && i_stall;

    assign o_valid     = r_out_valid;
    assign o_rms_value = r_out_rms;
    assign o_min_value = r_out_min;
    assign o_max_value = r_out_max;

endmodule

`default_nettype wire

// ===== hdl/windowed_rms_min_max.sv =====
// top level: windowed rms with running min and max, controller and datapath
//
// input channel: i_valid, i_sample, o_stall; a request is taken at an edge with
// i_valid high and o_stall low. output channel: o_valid, o_rms_value, o_min_value,
// o_max_value, i_stall; a result is taken at an edge with o_valid high and i_stall low.
// config channel: i_cfg_valid, i_cfg_data, o_cfg_ready (always high) writes
// stats_period; write it only while the block is idle.
// each sample gives one result. after the request, the controller runs the divide
// load, the 36-step divide by the fill count, the root load, the 16-step square
// root and the output step, both loops one bit a cycle in the datapath; o_valid
// rises once the output step loads the result, and no new request is taken until then.
// the output register lets a new sample be taken while a result waits; if the
// result is still stalled when the next one is ready, the block holds it back
// and keeps o_stall high until the output register frees.
// synchronous active-low reset empties the window, clears the sum, fill count,
// period counter, min and max, drops o_valid and sets stats_period to 500.
`default_nettype none

module windowed_rms_min_max (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [wrms_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [wrms_pkg::OUT_BITS-1:0]    o_rms_value,
    output logic [wrms_pkg::OUT_BITS-1:0]    o_min_value,
    output logic [wrms_pkg::OUT_BITS-1:0]    o_max_value,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [wrms_pkg::PERIOD_BITS-1:0] i_cfg_data
);
    import wrms_pkg::*;

    t_dp_cmd    s_cmd;
    t_dp_status s_status;
    t_state     s_state;
    logic       s_busy;

    wrms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (s_status),
        .o_cmd    (s_cmd),
        .o_state  (s_state),
        .o_busy   (s_busy)
    );

    wrms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_status    (s_status),
        .i_sample    (i_sample),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_rms_value (o_rms_value),
        .o_min_value (o_min_value),
        .o_max_value (o_max_value)
    );

    assign o_stall     = s_busy;
    assign o_cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after taking a request");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_value <= o_max_value))
        else $error("result minimum above maximum");

    a_valid_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(s_state) == ST_OUT))
        else $error("result shown outside the output step");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_state != ST_IDLE) |-> ((s_status.fill != '0)
            && (s_status.fill <= FILL_BITS'(WINDOW_LEN))))
        else $error("fill count out of range while working");
`endif

endmodule

`default_nettype wire
